// ===== rtl/control_datagram_deframer_assert.svh =====
// assertion macros for the port-level checker file
`ifndef CONTROL_DATAGRAM_DEFRAMER_ASSERT_SVH
`define CONTROL_DATAGRAM_DEFRAMER_ASSERT_SVH

// clocked property, ignored while reset is high
`define CDD_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cdd assertion failed");

// clocked property, checked during reset too
`define CDD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cdd assertion failed");

`endif

// ===== rtl/cdd_pkg.sv =====
// types, constants and the crc helper of the control datagram deframer
package cdd_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int SIZE_BITS   = 16;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    PH_DGRAM   = 2'd0,
    PH_CMDHDR  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_PAD     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_IGNORED = 3'd1,
    ST_ODD     = 3'd2,
    ST_SHORT   = 3'd3,
    ST_MAGIC   = 3'd4,
    ST_CRC     = 3'd5,
    ST_HEADER  = 3'd6,
    ST_PARTIAL = 3'd7
  } status_t;

  typedef enum logic {
    REG_MAGIC = 1'b0,
    REG_UID   = 1'b1
  } reg_t;

  typedef struct packed {
    logic [7:0]  data_in;
    logic        last_byte;
    logic [31:0] sender_uid;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] command;
    logic [7:0]  payload_byte;
    logic        first_of_payload;
    logic        last_of_payload;
    logic        end_of_datagram;
    logic [2:0]  status;
  } out_item_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/cdd_front.sv =====
// front part: parses bytes, keeps the crc and builds result transactions
module cdd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  cdd_pkg::in_item_t   item,
  input  logic [31:0]         magic_value,
  input  logic [31:0]         own_uid,
  output logic                push,
  output cdd_pkg::out_item_t  result
);

  logic [cdd_pkg::LENGTH_BITS-1:0] byte_count, byte_count_next;
  logic [1:0]                      size_mod4, size_mod4_next;
  logic                            sender_ignored, sender_ignored_next;
  logic [31:0]                     received_magic, received_magic_next;
  logic [31:0]                     received_crc, received_crc_next;
  logic [31:0]                     running_crc, running_crc_next;
  logic [31:0]                     command_header, command_header_next;
  cdd_pkg::phase_t                 parse_phase, parse_phase_next;
  logic [cdd_pkg::SIZE_BITS-1:0]   bytes_left, bytes_left_next;

  logic [cdd_pkg::SIZE_BITS-1:0] size, dec;
  logic [1:0]                    pad;
  cdd_pkg::kind_t                kind;
  logic [15:0]                   cmd;
  logic                          first, lastp;
  cdd_pkg::status_t              status;

  always_comb begin
    byte_count_next     = byte_count;
    size_mod4_next      = size_mod4 + 2'd1;
    received_magic_next = received_magic;
    received_crc_next   = received_crc;
    running_crc_next    = running_crc;
    command_header_next = command_header;
    parse_phase_next    = parse_phase;
    bytes_left_next     = bytes_left;
    kind  = cdd_pkg::KIND_NONE;
    cmd   = 16'd0;
    first = 1'b0;
    lastp = 1'b0;
    size  = command_header[31:16];
    dec   = '0;
    pad   = 2'd0;

    sender_ignored_next = (byte_count == '0)
        ? ((item.sender_uid != 32'd0) && (item.sender_uid != own_uid))
        : sender_ignored;

    if (parse_phase == cdd_pkg::PH_DGRAM) begin
      if (byte_count < cdd_pkg::LENGTH_BITS'(4)) begin
        received_magic_next = {received_magic[23:0], item.data_in};
      end else begin
        received_crc_next = {received_crc[23:0], item.data_in};
      end
      if (byte_count >= cdd_pkg::LENGTH_BITS'(7)) begin
        parse_phase_next = cdd_pkg::PH_CMDHDR;
        bytes_left_next  = '0;
      end
    end else begin
      running_crc_next = cdd_pkg::crc_byte(running_crc, item.data_in);
      case (parse_phase)
        cdd_pkg::PH_CMDHDR: begin
          command_header_next = {command_header[23:0], item.data_in};
          bytes_left_next     = bytes_left + 1'b1;
          if (bytes_left_next >= cdd_pkg::SIZE_BITS'(4)) begin
            if (command_header_next[31:16] == '0) begin
              kind            = cdd_pkg::KIND_EMPTY;
              cmd             = command_header_next[15:0];
              bytes_left_next = '0;
            end else begin
              parse_phase_next = cdd_pkg::PH_PAYLOAD;
              bytes_left_next  = command_header_next[31:16];
            end
          end
        end
        cdd_pkg::PH_PAYLOAD: begin
          kind  = cdd_pkg::KIND_PAYLOAD;
          cmd   = command_header[15:0];
          first = (bytes_left == size);
          lastp = (bytes_left <= cdd_pkg::SIZE_BITS'(1));
          dec   = (bytes_left != '0) ? bytes_left - 1'b1 : '0;
          bytes_left_next = dec;
          if (dec == '0) begin
            pad = 2'd0 - size[1:0];
            if (pad != 2'd0) begin
              parse_phase_next = cdd_pkg::PH_PAD;
              bytes_left_next  = cdd_pkg::SIZE_BITS'(pad);
            end else begin
              parse_phase_next = cdd_pkg::PH_CMDHDR;
            end
          end
        end
        default: begin
          dec = (bytes_left != '0) ? bytes_left - 1'b1 : '0;
          bytes_left_next = dec;
          if (dec == '0) begin
            parse_phase_next = cdd_pkg::PH_CMDHDR;
          end
        end
      endcase
    end

    if (byte_count != '1) begin
      byte_count_next = byte_count + 1'b1;
    end

    if (sender_ignored_next) begin
      kind  = cdd_pkg::KIND_NONE;
      cmd   = 16'd0;
      first = 1'b0;
      lastp = 1'b0;
    end

    status = cdd_pkg::ST_OK;
    if (item.last_byte) begin
      if (sender_ignored_next) begin
        status = cdd_pkg::ST_IGNORED;
      end else if (size_mod4_next != 2'd0) begin
        status = cdd_pkg::ST_ODD;
      end else if (byte_count_next < cdd_pkg::LENGTH_BITS'(8)) begin
        status = cdd_pkg::ST_SHORT;
      end else if (received_magic_next != magic_value) begin
        status = cdd_pkg::ST_MAGIC;
      end else if (received_crc_next != ~running_crc_next) begin
        status = cdd_pkg::ST_CRC;
      end else if (parse_phase_next == cdd_pkg::PH_CMDHDR && bytes_left_next != '0) begin
        status = cdd_pkg::ST_HEADER;
      end else if (parse_phase_next == cdd_pkg::PH_PAYLOAD) begin
        status = cdd_pkg::ST_PARTIAL;
      end
    end

    push                    = accept && ((kind != cdd_pkg::KIND_NONE) || item.last_byte);
    result.kind             = kind;
    result.command          = cmd;
    result.payload_byte     = (kind == cdd_pkg::KIND_PAYLOAD) ? item.data_in : 8'd0;
    result.first_of_payload = first;
    result.last_of_payload  = lastp;
    result.end_of_datagram  = item.last_byte;
    result.status           = status;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && item.last_byte)) begin
      byte_count     <= '0;
      size_mod4      <= 2'd0;
      sender_ignored <= 1'b0;
      received_magic <= 32'd0;
      received_crc   <= 32'd0;
      running_crc    <= cdd_pkg::CRC_PRESET;
      command_header <= 32'd0;
      parse_phase    <= cdd_pkg::PH_DGRAM;
      bytes_left     <= '0;
    end else if (accept) begin
      byte_count     <= byte_count_next;
      size_mod4      <= size_mod4_next;
      sender_ignored <= sender_ignored_next;
      received_magic <= received_magic_next;
      received_crc   <= received_crc_next;
      running_crc    <= running_crc_next;
      command_header <= command_header_next;
      parse_phase    <= parse_phase_next;
      bytes_left     <= bytes_left_next;
    end
  end

endmodule

// ===== rtl/cdd_queue.sv =====
// back part: two-entry result queue that drives the output channel
module cdd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cdd_pkg::out_item_t push_item,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output cdd_pkg::out_item_t out_data
);

  cdd_pkg::out_item_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/control_datagram_deframer.sv =====
// top level of the control datagram deframer
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  in_data (one datagram byte)
//  out      output     out_valid/out_stall out_data (payload byte, flag or verdict)
//  apb      input      psel/penable/pready magic_value at 0x0, own_uid at 0x4
//
// one byte is taken per clock while in_stall is low; the result of a byte
// enters the queue in the same cycle and, if the queue was empty, is shown on
// out from the next cycle on; the two-entry queue between parser and output
// sets the stall: in_stall is high while both entries are filled
// rst is synchronous and clears parser state, queue and registers
// a final byte returns the parser to its start state for the next datagram
module control_datagram_deframer (
  input  logic               clk,
  input  logic               rst,
  // byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  cdd_pkg::in_item_t  in_data,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output cdd_pkg::out_item_t out_data,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic               full;
  logic               accept;
  logic               push;
  cdd_pkg::out_item_t push_item;
  logic [31:0]        magic_value;
  logic [31:0]        own_uid;
  cdd_pkg::reg_t      reg_sel;

  // configuration registers, written in the access phase
  assign pready  = 1'b1;
  assign reg_sel = cdd_pkg::reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value <= 32'd0;
      own_uid     <= 32'd0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        cdd_pkg::REG_MAGIC: magic_value <= pwdata;
        cdd_pkg::REG_UID:   own_uid     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      cdd_pkg::REG_MAGIC: prdata = magic_value;
      cdd_pkg::REG_UID:   prdata = own_uid;
      default:            prdata = 32'd0;
    endcase
  end

  // byte transaction taken whenever the queue has room
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  cdd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (in_data),
    .magic_value (magic_value),
    .own_uid     (own_uid),
    .push        (push),
    .result      (push_item)
  );

  cdd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/cdd_checker.sv =====
// port-level checks of the control datagram deframer and their bind
`include "control_datagram_deframer_assert.svh"

module cdd_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input cdd_pkg::out_item_t out_data,
  input logic               pready
);

  // a result with nothing in it must be a verdict
  `CDD_ASSERT_RST(a_empty_is_verdict, clk, rst, (out_valid && out_data.kind == cdd_pkg::KIND_NONE) |-> out_data.end_of_datagram)

  // status is only given with the verdict
  `CDD_ASSERT_RST(a_status_only_at_end, clk, rst, (out_valid && !out_data.end_of_datagram) |-> (out_data.status == cdd_pkg::ST_OK))

  // first and last marks only on payload bytes
  `CDD_ASSERT_RST(a_marks_on_payload, clk, rst, (out_valid && (out_data.first_of_payload || out_data.last_of_payload)) |-> (out_data.kind == cdd_pkg::KIND_PAYLOAD))

  // a stalled result stays offered
  `CDD_ASSERT_RST(a_valid_holds, clk, rst, (out_valid && out_stall) |=> out_valid)

  // register port never waits
  `CDD_ASSERT_ALWAYS(a_pready_high, clk, pready)

endmodule

bind control_datagram_deframer cdd_checker u_cdd_checker (.*);

// ===== tb/sv/cdd_checker.sv =====
// checker: predicts deframer results from accepted bytes and compares them
module tb_cdd_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  cdd_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  cdd_pkg::out_item_t out_data,
  input  logic [31:0]        magic_value,
  input  logic [31:0]        own_uid,
  output int                 errors,
  output int                 pending
);
  import cdd_pkg::*;

  out_item_t expected_q[$];

  logic [LENGTH_BITS-1:0] n_bytes;
  logic [1:0]  len_mod4;
  logic        ignored;
  logic [31:0] rx_magic, rx_crc, crc_acc, cmd_hdr;
  phase_t      phase;
  logic [15:0] remaining;

  task automatic clear_frame();
    n_bytes = '0; len_mod4 = '0; ignored = 1'b0;
    rx_magic = '0; rx_crc = '0; crc_acc = CRC_PRESET; cmd_hdr = '0;
    phase = PH_DGRAM; remaining = '0;
  endtask

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    c ^= {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic predict_byte(in_item_t it);
    out_item_t r;
    logic [15:0] sz;
    logic [1:0] pad;
    r = '0;
    if (n_bytes == 0) ignored = (it.sender_uid != 0) && (it.sender_uid != own_uid);
    if (phase == PH_DGRAM) begin
      if (n_bytes < 4) rx_magic = {rx_magic[23:0], it.data_in};
      else rx_crc = {rx_crc[23:0], it.data_in};
      if (n_bytes >= 7) begin
        phase = PH_CMDHDR; remaining = 0;
      end
    end else begin
      crc_acc = crc_step(crc_acc, it.data_in);
      sz = cmd_hdr[31:16];
      case (phase)
        PH_CMDHDR: begin
          cmd_hdr = {cmd_hdr[23:0], it.data_in};
          remaining++;
          if (remaining >= 4) begin
            sz = cmd_hdr[31:16];
            if (sz == 0) begin
              r.kind = KIND_EMPTY; r.command = cmd_hdr[15:0]; remaining = 0;
            end else begin
              phase = PH_PAYLOAD; remaining = sz;
            end
          end
        end
        PH_PAYLOAD: begin
          r.kind = KIND_PAYLOAD; r.command = cmd_hdr[15:0]; r.payload_byte = it.data_in;
          r.first_of_payload = (remaining == sz);
          r.last_of_payload = (remaining <= 1);
          if (remaining > 0) remaining--;
          if (remaining == 0) begin
            pad = 2'd0 - sz[1:0];
            if (pad != 0) begin
              phase = PH_PAD; remaining = {14'd0, pad};
            end else begin
              phase = PH_CMDHDR; remaining = 0;
            end
          end
        end
        default: begin
          if (remaining > 0) remaining--;
          if (remaining == 0) phase = PH_CMDHDR;
        end
      endcase
    end
    if (n_bytes != '1) n_bytes++;
    len_mod4++;
    if (ignored) r = '0;
    if (it.last_byte) begin
      r.end_of_datagram = 1'b1;
      if (ignored) r.status = ST_IGNORED;
      else if (len_mod4 != 0) r.status = ST_ODD;
      else if (n_bytes < 8) r.status = ST_SHORT;
      else if (rx_magic != magic_value) r.status = ST_MAGIC;
      else if (rx_crc != ~crc_acc) r.status = ST_CRC;
      else if (phase == PH_CMDHDR && remaining != 0) r.status = ST_HEADER;
      else if (phase == PH_PAYLOAD) r.status = ST_PARTIAL;
      else r.status = ST_OK;
    end
    if (r.kind != KIND_NONE || it.last_byte) expected_q.push_back(r);
    if (it.last_byte) clear_frame();
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t w;
    if (expected_q.size() == 0) begin
      report("unexpected transaction", got, 0);
      return;
    end
    w = expected_q.pop_front();
    if (got.kind != w.kind) report("kind", got.kind, w.kind);
    if (got.command != w.command) report("command", got.command, w.command);
    if (got.payload_byte != w.payload_byte) report("payload_byte", got.payload_byte, w.payload_byte);
    if (got.first_of_payload != w.first_of_payload)
      report("first_of_payload", got.first_of_payload, w.first_of_payload);
    if (got.last_of_payload != w.last_of_payload)
      report("last_of_payload", got.last_of_payload, w.last_of_payload);
    if (got.end_of_datagram != w.end_of_datagram)
      report("end_of_datagram", got.end_of_datagram, w.end_of_datagram);
    if (got.status != w.status) report("status", got.status, w.status);
  endtask

  initial begin
    errors = 0;
    pending = 0;
    clear_frame();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) compare_result(out_data);
      if (in_valid && !in_stall) predict_byte(in_data);
    end
    pending = expected_q.size();
  end
endmodule

// ===== tb/sv/tb_control_datagram_deframer.sv =====
// testbench top: builds datagrams, drives the deframer and gives the verdict
module tb_control_datagram_deframer;
  import cdd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // copies of the registers as last written, shared with the checker
  logic [31:0] magic_reg = '0;
  logic [31:0] uid_reg = '0;

  int errors, pending;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int n_items = 0;

  // frame under construction
  byte unsigned frame[$];

  always #2 clk = ~clk;

  control_datagram_deframer dut (.*);

  tb_cdd_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .magic_value(magic_reg), .own_uid(uid_reg), .errors, .pending
  );

  // consumer stall, random per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // generous bound on the whole run
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // one apb write, setup then access
  task automatic write_reg(reg_t idx, logic [31:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_MAGIC) magic_reg = val;
    else uid_reg = val;
  endtask

  // stop sending and wait until the block has drained
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // send one byte as a transaction, random gap in front
  task automatic send_byte(byte unsigned b, bit last, logic [31:0] uid);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_in: b, last_byte: last, sender_uid: uid};
    do @(posedge clk); while (in_stall);
    n_items++;
  endtask

  // sender uid for a frame: mostly accepted ones
  function automatic logic [31:0] pick_uid();
    case ($urandom_range(9))
      0, 1, 2: return 32'd0;
      3:       return $urandom;
      default: return uid_reg;
    endcase
  endfunction

  task automatic send_frame(logic [31:0] uid);
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1, uid);
  endtask

  // reflected crc over frame bytes from offset 8
  function automatic logic [31:0] frame_crc();
    logic [31:0] c;
    c = 32'hFFFFFFFF;
    for (int i = 8; i < frame.size(); i++) begin
      c ^= {24'd0, frame[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return ~c;
  endfunction

  // well-formed frame with nc commands, then maybe a defect or two
  task automatic build_frame(int nc, int max_size, bit damage);
    int sz;
    logic [31:0] crc;
    frame.delete();
    for (int i = 0; i < 4; i++) frame.push_back(magic_reg[31 - 8*i -: 8]);
    repeat (4) frame.push_back(8'h00);
    for (int c = 0; c < nc; c++) begin
      sz = ($urandom_range(4) == 0) ? 0 : $urandom_range(max_size);
      frame.push_back(sz[15:8]); frame.push_back(sz[7:0]);
      frame.push_back(8'($urandom)); frame.push_back(8'($urandom));
      for (int k = 0; k < sz; k++) frame.push_back(8'($urandom));
      while (frame.size() % 4 != 0) frame.push_back($urandom_range(1) ? 8'h00 : 8'($urandom));
    end
    if (damage) begin
      case ($urandom_range(4))
        0: frame.push_back(8'($urandom));
        1: repeat (4) frame.push_back(8'h00);          // empty command with code zero
        2: begin                                       // partial payload
          frame.push_back(8'h00); frame.push_back(8'h09);
          frame.push_back(8'($urandom)); frame.push_back(8'($urandom));
        end
        3: frame[$urandom_range(3)] ^= 8'h01;         // wrong magic
        default: if (frame.size() > 8) frame[$urandom_range(frame.size() - 1, 8)] ^= 8'h80;
      endcase
    end
    if (!(damage && frame.size() > 8 && frame[frame.size()-1] == 8'hFF && 0)) begin
      crc = frame_crc();
      for (int i = 0; i < 4; i++) frame[4 + i] = crc[31 - 8*i -: 8];
    end
    // payload damage after crc so the crc error case is reached
    if (damage && $urandom_range(3) == 0 && frame.size() > 8)
      frame[$urandom_range(frame.size() - 1, 8)] ^= 8'h01;
  endtask

  task automatic random_phase(int budget);
    int target;
    target = n_items + budget;
    while (n_items < target) begin
      if ($urandom_range(9) == 0) begin
        // noise: random bytes of random length
        frame.delete();
        repeat ($urandom_range(1, 14)) frame.push_back(8'($urandom));
        send_frame($urandom_range(1) ? 32'd0 : $urandom);
      end else begin
        build_frame($urandom_range(0, 4), ($urandom_range(15) == 0) ? 40 : 7,
                    $urandom_range(3) == 0);
        send_frame(pick_uid());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_MAGIC, 32'hA5C3_0F81);
    write_reg(REG_UID, 32'd1000);

    // directed: short frames, extremes, several verdicts
    frame = '{8'hFF, 8'h00, 8'hFF};
    send_frame(32'd0);                               // odd size
    frame = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(32'd0);                               // too short
    build_frame(1, 3, 0);
    send_frame(32'hFFFF_FFFF);                       // ignored sender
    build_frame(2, 5, 0);
    send_frame(32'd1000);                            // ok
    // one command with all-ones bytes and size 1
    frame.delete();
    for (int i = 0; i < 4; i++) frame.push_back(magic_reg[31 - 8*i -: 8]);
    repeat (4) frame.push_back(8'h00);
    frame.push_back(8'h00); frame.push_back(8'h01);
    frame.push_back(8'hFF); frame.push_back(8'hFF);
    frame.push_back(8'hFF); frame.push_back(8'hFF); frame.push_back(8'hFF);
    frame.push_back(8'hFF);
    begin
      logic [31:0] c;
      c = frame_crc();
      for (int i = 0; i < 4; i++) frame[4 + i] = c[31 - 8*i -: 8];
    end
    send_frame(32'd0);
    drain();

    // extreme register settings
    write_reg(REG_MAGIC, 32'h0000_0000);
    write_reg(REG_UID, 32'hFFFF_FFFF);
    send_idle_pct = 32; recv_idle_pct = 63;
    random_phase(600);
    drain();

    write_reg(REG_MAGIC, 32'hFFFF_FFFF);
    write_reg(REG_UID, 32'h0000_0000);
    send_idle_pct = 63; recv_idle_pct = 32;
    random_phase(300);
    // sender holds off until everything is out
    drain();
    random_phase(300);
    drain();

    write_reg(REG_MAGIC, $urandom);
    write_reg(REG_UID, $urandom);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(600);
    // one payload of up to 300 bytes to cover wider size bits
    build_frame(1, 300, 0);
    send_frame(32'd0);

    drain();
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== control_datagram_deframer.f =====
+incdir+rtl
rtl/cdd_pkg.sv
rtl/cdd_front.sv
rtl/cdd_queue.sv
rtl/control_datagram_deframer.sv
rtl/cdd_checker.sv
tb/sv/cdd_checker.sv
tb/sv/tb_control_datagram_deframer.sv
